[design/cpcr_pkg.sv]
// shared types and constants for the circle pair collision resolver
// used by every module of the block; no dependencies
`timescale 1ns / 1ps

package cpcr_pkg;

	localparam int POS_W  = 20;
	localparam int RAD_W  = 16;
	localparam int MASS_W = 16;
	// contact distance, also the bound on |dx| and |dy| once the pair overlaps
	localparam int S_W    = RAD_W + 1;
	localparam int MSUM_W = MASS_W + 1;
	localparam int SQ_W   = 2 * S_W;
	localparam int LEN_W  = S_W;
	localparam int PA_W   = S_W + MASS_W;
	localparam int NUM_W  = PA_W + S_W;
	localparam int DEN_W  = MSUM_W + LEN_W;
	localparam int Q_W    = S_W + 1;

	localparam int SQRT_LAT = LEN_W;
	localparam int DIV_LAT  = Q_W + 1;
	localparam int PIPE_LAT = 4 + SQRT_LAT + 2 + DIV_LAT + 1;

	typedef enum logic [1:0] {
		OUT_APART    = 2'd0,
		OUT_RESOLVED = 2'd1,
		OUT_DEGEN    = 2'd2
	} outcome_t;

	typedef struct packed {
		logic signed [POS_W-1:0] first_x;
		logic signed [POS_W-1:0] first_y;
		logic signed [POS_W-1:0] second_x;
		logic signed [POS_W-1:0] second_y;
		logic [RAD_W-1:0]        first_radius;
		logic [RAD_W-1:0]        second_radius;
		logic [MASS_W-1:0]       first_mass;
		logic [MASS_W-1:0]       second_mass;
	} pair_t;

	typedef struct packed {
		logic signed [POS_W-1:0] new_first_x;
		logic signed [POS_W-1:0] new_first_y;
		logic signed [POS_W-1:0] new_second_x;
		logic signed [POS_W-1:0] new_second_y;
		outcome_t                outcome;
	} result_t;

	// what travels beside the square root and the dividers
	typedef struct packed {
		logic signed [POS_W-1:0] x1;
		logic signed [POS_W-1:0] y1;
		logic signed [POS_W-1:0] x2;
		logic signed [POS_W-1:0] y2;
		outcome_t                oc;
		logic                    neg_x;
		logic                    neg_y;
		logic [S_W-1:0]          ax;
		logic [S_W-1:0]          ay;
		logic [S_W-1:0]          s;
		logic [MASS_W-1:0]       m1;
		logic [MASS_W-1:0]       m2;
		logic [MSUM_W-1:0]       msum;
	} side_t;

endpackage

[design/cpcr_isqrt.sv]
// pipelined integer square root, one result bit per stage
// depends on cpcr_pkg
`timescale 1ns / 1ps

module cpcr_isqrt (
	input  logic                      clk,
	input  logic [cpcr_pkg::SQ_W-1:0] arg,
	output logic [cpcr_pkg::LEN_W-1:0] root
);
	import cpcr_pkg::*;

	localparam int RW = SQ_W + 1;

	logic [SQ_W-1:0] rem_s [LEN_W-1];
	logic [RW-1:0]   acc_s [LEN_W];

	for (genvar j = 0; j < LEN_W; j++) begin : g_stage
		localparam int K = LEN_W - 1 - j;
		logic [SQ_W-1:0] rem_in;
		logic [RW-1:0]   acc_in;
		logic [RW-1:0]   bitv;
		logic [RW-1:0]   trial;
		logic            take;

		if (j == 0) begin : g_first
			assign rem_in = arg;
			assign acc_in = '0;
		end else begin : g_next
			assign rem_in = rem_s[j-1];
			assign acc_in = acc_s[j-1];
		end

		always_comb begin
			bitv  = RW'(1) << (2 * K);
			trial = acc_in + bitv;
			take  = {1'b0, rem_in} >= trial;
		end

		always_ff @(posedge clk) begin
			acc_s[j] <= take ? ((acc_in >> 1) + bitv) : (acc_in >> 1);
		end

		if (j < LEN_W - 1) begin : g_rem
			always_ff @(posedge clk) begin
				rem_s[j] <= take ? (rem_in - trial[SQ_W-1:0]) : rem_in;
			end
		end
	end

	assign root = acc_s[LEN_W-1][LEN_W-1:0];

endmodule

[design/cpcr_div.sv]
// pipelined restoring divider giving round(num / den), halves up
// depends on cpcr_pkg
`timescale 1ns / 1ps

module cpcr_div (
	input  logic                       clk,
	input  logic [cpcr_pkg::NUM_W-1:0] num,
	input  logic [cpcr_pkg::DEN_W-1:0] den,
	output logic [cpcr_pkg::Q_W-1:0]   quo
);
	import cpcr_pkg::*;

	localparam int RW = NUM_W + 2;

	logic [RW-1:0]    rem_s [Q_W];
	logic [DEN_W:0]   dd_s  [Q_W];
	logic [Q_W-1:0]   q_s   [Q_W];

	// (2*num + den) / (2*den) rounds the plain quotient
	always_ff @(posedge clk) begin
		rem_s[0] <= {1'b0, num, 1'b0} + RW'(den);
		dd_s[0]  <= {den, 1'b0};
	end

	for (genvar j = 1; j <= Q_W; j++) begin : g_stage
		localparam int SH = Q_W - j;
		logic [RW-1:0] trial;
		logic          take;

		always_comb begin
			trial = RW'(dd_s[j-1]) << SH;
			take  = rem_s[j-1] >= trial;
		end

		if (j < Q_W) begin : g_carry
			always_ff @(posedge clk) begin
				rem_s[j] <= take ? (rem_s[j-1] - trial) : rem_s[j-1];
				dd_s[j]  <= dd_s[j-1];
			end
		end

		if (j == 1) begin : g_q0
			always_ff @(posedge clk) begin
				q_s[0] <= Q_W'(take);
			end
		end else begin : g_qn
			always_ff @(posedge clk) begin
				q_s[j-1] <= {q_s[j-2][Q_W-2:0], take};
			end
		end
	end

	assign quo = q_s[Q_W-1];

endmodule

[design/circle_pair_collision_resolve.sv]
// Narrow-phase push-apart for one pair of circles per clock. A pair is taken
// at every edge where start is high (busy is always low) and its result shows
// on result with done high for one cycle; results come out in the order the
// pairs went in. The pipeline is built around the 17-stage square root of the
// squared centre distance and the 19-stage dividers that form the mass-weighted
// push. The receiver cannot stall the block.
// depends on cpcr_pkg, cpcr_isqrt, cpcr_div
`timescale 1ns / 1ps

module circle_pair_collision_resolve (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  cpcr_pkg::pair_t   pair,
	output logic              done,
	output cpcr_pkg::result_t result
);
	import cpcr_pkg::*;

	function automatic logic signed [POS_W-1:0] sat(input logic signed [POS_W+1:0] v);
		logic signed [POS_W+1:0] hi;
		logic signed [POS_W+1:0] lo;
		hi = {3'b000, {(POS_W-1){1'b1}}};
		lo = {3'b111, {(POS_W-1){1'b0}}};
		if (v > hi) begin
			return hi[POS_W-1:0];
		end else if (v < lo) begin
			return lo[POS_W-1:0];
		end
		return v[POS_W-1:0];
	endfunction

	assign busy = 1'b0;

	// stage 1: offsets and contact distance
	logic                  v_s1;
	pair_t                 p_s1;
	logic signed [POS_W:0] dx_s1, dy_s1;
	logic [S_W-1:0]        s_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start & ~busy;
		end
	end

	always_ff @(posedge clk) begin
		p_s1  <= pair;
		dx_s1 <= (POS_W+1)'(pair.first_x) - (POS_W+1)'(pair.second_x);
		dy_s1 <= (POS_W+1)'(pair.first_y) - (POS_W+1)'(pair.second_y);
		s_s1  <= S_W'(pair.first_radius) + S_W'(pair.second_radius);
	end

	// stage 2: magnitudes and the per-axis early-out
	logic [POS_W:0]    adx, ady;
	logic              v_s2, coarse_s2, negx_s2, negy_s2;
	pair_t             p_s2;
	logic [S_W-1:0]    ax_s2, ay_s2, s_s2;
	logic [MSUM_W-1:0] msum_s2;

	always_comb begin
		adx = dx_s1[POS_W] ? (~dx_s1 + 1'b1) : dx_s1;
		ady = dy_s1[POS_W] ? (~dy_s1 + 1'b1) : dy_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		p_s2      <= p_s1;
		coarse_s2 <= (adx < (POS_W+1)'(s_s1)) && (ady < (POS_W+1)'(s_s1));
		negx_s2   <= dx_s1[POS_W];
		negy_s2   <= dy_s1[POS_W];
		ax_s2     <= adx[S_W-1:0];
		ay_s2     <= ady[S_W-1:0];
		s_s2      <= s_s1;
		msum_s2   <= MSUM_W'(p_s1.first_mass) + MSUM_W'(p_s1.second_mass);
	end

	// stage 3: squares
	logic              v_s3, coarse_s3, negx_s3, negy_s3;
	pair_t             p_s3;
	logic [S_W-1:0]    ax_s3, ay_s3, s_s3;
	logic [MSUM_W-1:0] msum_s3;
	logic [SQ_W-1:0]   ax2_s3, ay2_s3, ss_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		p_s3      <= p_s2;
		coarse_s3 <= coarse_s2;
		negx_s3   <= negx_s2;
		negy_s3   <= negy_s2;
		ax_s3     <= ax_s2;
		ay_s3     <= ay_s2;
		s_s3      <= s_s2;
		msum_s3   <= msum_s2;
		ax2_s3    <= SQ_W'(ax_s2) * SQ_W'(ax_s2);
		ay2_s3    <= SQ_W'(ay_s2) * SQ_W'(ay_s2);
		ss_s3     <= SQ_W'(s_s2) * SQ_W'(s_s2);
	end

	// stage 4: exact overlap test and outcome
	logic [SQ_W:0]   d2;
	outcome_t        oc;
	logic            v_s4;
	side_t           side_s4;
	logic [SQ_W-1:0] sq_arg_s4;

	always_comb begin
		d2 = {1'b0, ax2_s3} + {1'b0, ay2_s3};
		if (!(coarse_s3 && (d2 < {1'b0, ss_s3}))) begin
			oc = OUT_APART;
		end else if ((d2 == '0) || (msum_s3 == '0)) begin
			oc = OUT_DEGEN;
		end else begin
			oc = OUT_RESOLVED;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		side_s4.x1    <= p_s3.first_x;
		side_s4.y1    <= p_s3.first_y;
		side_s4.x2    <= p_s3.second_x;
		side_s4.y2    <= p_s3.second_y;
		side_s4.oc    <= oc;
		side_s4.neg_x <= negx_s3;
		side_s4.neg_y <= negy_s3;
		side_s4.ax    <= ax_s3;
		side_s4.ay    <= ay_s3;
		side_s4.s     <= s_s3;
		side_s4.m1    <= p_s3.first_mass;
		side_s4.m2    <= p_s3.second_mass;
		side_s4.msum  <= msum_s3;
		sq_arg_s4     <= d2[SQ_W-1:0];
	end

	// centre distance
	logic [LEN_W-1:0] len;
	logic             sq_v_s  [SQRT_LAT];
	side_t            sq_side_s [SQRT_LAT];

	cpcr_isqrt u_isqrt (
		.clk  (clk),
		.arg  (sq_arg_s4),
		.root (len)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SQRT_LAT; i++) begin
				sq_v_s[i] <= 1'b0;
			end
		end else begin
			sq_v_s[0] <= v_s4;
			for (int i = 1; i < SQRT_LAT; i++) begin
				sq_v_s[i] <= sq_v_s[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		sq_side_s[0] <= side_s4;
		for (int i = 1; i < SQRT_LAT; i++) begin
			sq_side_s[i] <= sq_side_s[i-1];
		end
	end

	// stage 5: depth, denominator and mass-weighted depths
	side_t            sq_out;
	logic [S_W-1:0]   depth;
	logic             v_s5;
	side_t            side_s5;
	logic [DEN_W-1:0] den_s5;
	logic [PA_W-1:0]  pa_s5, pb_s5;

	always_comb begin
		sq_out = sq_side_s[SQRT_LAT-1];
		depth  = sq_out.s - len;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else begin
			v_s5 <= sq_v_s[SQRT_LAT-1];
		end
	end

	always_ff @(posedge clk) begin
		side_s5 <= sq_out;
		den_s5  <= DEN_W'(sq_out.msum) * DEN_W'(len);
		pa_s5   <= PA_W'(depth) * PA_W'(sq_out.m2);
		pb_s5   <= PA_W'(depth) * PA_W'(sq_out.m1);
	end

	// stage 6: numerators
	logic             v_s6;
	side_t            side_s6;
	logic [DEN_W-1:0] den_s6;
	logic [NUM_W-1:0] n1x_s6, n1y_s6, n2x_s6, n2y_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		side_s6 <= side_s5;
		den_s6  <= den_s5;
		n1x_s6  <= NUM_W'(pa_s5) * NUM_W'(side_s5.ax);
		n1y_s6  <= NUM_W'(pa_s5) * NUM_W'(side_s5.ay);
		n2x_s6  <= NUM_W'(pb_s5) * NUM_W'(side_s5.ax);
		n2y_s6  <= NUM_W'(pb_s5) * NUM_W'(side_s5.ay);
	end

	// push magnitudes
	logic [Q_W-1:0] q1x, q1y, q2x, q2y;
	logic           dv_v_s  [DIV_LAT];
	side_t          dv_side_s [DIV_LAT];

	cpcr_div u_div_1x (.clk(clk), .num(n1x_s6), .den(den_s6), .quo(q1x));
	cpcr_div u_div_1y (.clk(clk), .num(n1y_s6), .den(den_s6), .quo(q1y));
	cpcr_div u_div_2x (.clk(clk), .num(n2x_s6), .den(den_s6), .quo(q2x));
	cpcr_div u_div_2y (.clk(clk), .num(n2y_s6), .den(den_s6), .quo(q2y));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DIV_LAT; i++) begin
				dv_v_s[i] <= 1'b0;
			end
		end else begin
			dv_v_s[0] <= v_s6;
			for (int i = 1; i < DIV_LAT; i++) begin
				dv_v_s[i] <= dv_v_s[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		dv_side_s[0] <= side_s6;
		for (int i = 1; i < DIV_LAT; i++) begin
			dv_side_s[i] <= dv_side_s[i-1];
		end
	end

	// final stage: apply signs, move, saturate
	side_t                   fin;
	logic signed [Q_W:0]     p1x, p1y, p2x, p2y;
	result_t                 res;

	always_comb begin
		fin = dv_side_s[DIV_LAT-1];
		p1x = fin.neg_x ? -$signed({1'b0, q1x}) : $signed({1'b0, q1x});
		p1y = fin.neg_y ? -$signed({1'b0, q1y}) : $signed({1'b0, q1y});
		p2x = fin.neg_x ? -$signed({1'b0, q2x}) : $signed({1'b0, q2x});
		p2y = fin.neg_y ? -$signed({1'b0, q2y}) : $signed({1'b0, q2y});
		res.outcome = fin.oc;
		if (fin.oc == OUT_RESOLVED) begin
			res.new_first_x  = sat((POS_W+2)'(fin.x1) + (POS_W+2)'(p1x));
			res.new_first_y  = sat((POS_W+2)'(fin.y1) + (POS_W+2)'(p1y));
			res.new_second_x = sat((POS_W+2)'(fin.x2) - (POS_W+2)'(p2x));
			res.new_second_y = sat((POS_W+2)'(fin.y2) - (POS_W+2)'(p2y));
		end else begin
			res.new_first_x  = fin.x1;
			res.new_first_y  = fin.y1;
			res.new_second_x = fin.x2;
			res.new_second_y = fin.y2;
		end
	end

	logic    done_q;
	result_t result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= dv_v_s[DIV_LAT-1];
		end
	end

	always_ff @(posedge clk) begin
		result_q <= res;
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

[design/cpcr_check.sv]
// port-level checks for the circle pair collision resolver, bound to the top
// depends on cpcr_pkg and circle_pair_collision_resolve
`timescale 1ns / 1ps

module cpcr_check (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input cpcr_pkg::pair_t   pair,
	input logic              done,
	input cpcr_pkg::result_t result
);
	import cpcr_pkg::*;

	// every item gives a result a fixed latency later
	a_start_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##PIPE_LAT done)
		else $error("item accepted without its result");

	a_done_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, PIPE_LAT))
		else $error("result without an accepted item");

	// untouched pairs pass positions through
	a_pass_first: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.outcome != OUT_RESOLVED)
		|-> (result.new_first_x == $past(pair.first_x, PIPE_LAT)
			&& result.new_second_y == $past(pair.second_y, PIPE_LAT)))
		else $error("unresolved pair changed position");

	a_no_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");

endmodule

bind circle_pair_collision_resolve cpcr_check u_cpcr_check (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.pair   (pair),
	.done   (done),
	.result (result)
);

[test/circle_pair_collision_resolve_tb.sv]
// testbench for circle_pair_collision_resolve: directed and random circle pairs
// checked against an in-bench predictor of the mass-weighted push-apart
// depends on cpcr_pkg and the block under test
`timescale 1ns / 1ps

module circle_pair_collision_resolve_tb;
	import cpcr_pkg::*;

	localparam int POS_MAX = (1 << (POS_W - 1)) - 1;
	localparam int POS_MIN = -(1 << (POS_W - 1));

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    start = 1'b0;
	logic    busy;
	pair_t   pair = '0;
	logic    done;
	result_t result;

	pair_t   pending_pairs[$];
	result_t expected_results[$];
	int      mismatches = 0;
	int      checked = 0;
	int      n_resolved = 0, n_degen = 0, n_apart = 0;
	int      gap = 0;
	bit      feeding_done = 1'b0;

	circle_pair_collision_resolve dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.pair(pair), .done(done), .result(result)
	);

	always #5 clk = ~clk;

	function automatic longint unsigned mag(longint v);
		return (v < 0) ? longint'(-v) : longint'(v);
	endfunction

	function automatic logic signed [POS_W-1:0] clamp_pos(longint v);
		if (v > POS_MAX) v = POS_MAX;
		if (v < POS_MIN) v = POS_MIN;
		return v[POS_W-1:0];
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned n);
		longint unsigned r, lo, hi, mid;
		lo = 0;
		hi = 1 << 32;
		// largest r with r*r <= n
		while (lo < hi) begin
			mid = (lo + hi + 1) >> 1;
			if (mid * mid <= n) lo = mid;
			else hi = mid - 1;
		end
		r = lo;
		return r;
	endfunction

	function automatic longint push_amount(longint unsigned depth, longint unsigned m,
		longint comp, longint unsigned den);
		longint unsigned num, q;
		num = depth * m * mag(comp);
		q = (2 * num + den) / (2 * den);
		return (comp < 0) ? -longint'(q) : longint'(q);
	endfunction

	function automatic result_t resolve_pair(pair_t p);
		result_t r;
		longint x1, y1, x2, y2, dx, dy;
		longint unsigned s, ax, ay, d2, msum, len, depth, den;
		x1 = p.first_x; y1 = p.first_y; x2 = p.second_x; y2 = p.second_y;
		dx = x1 - x2; dy = y1 - y2;
		s = longint'(p.first_radius) + longint'(p.second_radius);
		ax = mag(dx); ay = mag(dy);
		r.new_first_x = p.first_x; r.new_first_y = p.first_y;
		r.new_second_x = p.second_x; r.new_second_y = p.second_y;
		r.outcome = OUT_APART;
		if (ax < s && ay < s) begin
			d2 = ax * ax + ay * ay;
			if (d2 < s * s) begin
				msum = longint'(p.first_mass) + longint'(p.second_mass);
				if (d2 == 0 || msum == 0) begin
					r.outcome = OUT_DEGEN;
				end else begin
					len = int_sqrt(d2);
					depth = s - len;
					den = msum * len;
					r.new_first_x = clamp_pos(x1 + push_amount(depth, p.second_mass, dx, den));
					r.new_first_y = clamp_pos(y1 + push_amount(depth, p.second_mass, dy, den));
					r.new_second_x = clamp_pos(x2 - push_amount(depth, p.first_mass, dx, den));
					r.new_second_y = clamp_pos(y2 - push_amount(depth, p.first_mass, dy, den));
					r.outcome = OUT_RESOLVED;
				end
			end
		end
		return r;
	endfunction

	function automatic int pick_gap();
		if ($urandom_range(0, 2) == 0) return 0;
		if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
		return $urandom_range(0, 3);
	endfunction

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				expected_results.insert(expected_results.size(), resolve_pair(pair));
			end
			if (start && busy) begin
				// hold the item until taken
			end else if (gap > 0) begin
				gap <= gap - 1;
				start <= 1'b0;
			end else if (pending_pairs.size() > 0) begin
				pair <= pending_pairs.pop_front();
				start <= 1'b1;
				gap <= pick_gap();
			end else begin
				start <= 1'b0;
				if (!start) feeding_done <= 1'b1;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		result_t e;
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %h", result);
			end else begin
				e = expected_results.pop_front();
				checked++;
				case (e.outcome)
					OUT_RESOLVED: n_resolved++;
					OUT_DEGEN: n_degen++;
					default: n_apart++;
				endcase
				if (result !== e) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"result mismatch: expected %h (%0d %0d %0d %0d oc %0d)",
							" got %h (%0d %0d %0d %0d oc %0d)"},
							e, e.new_first_x, e.new_first_y, e.new_second_x, e.new_second_y,
							e.outcome, result, result.new_first_x, result.new_first_y,
							result.new_second_x, result.new_second_y, result.outcome);
				end
			end
		end
	end

	function automatic pair_t make_pair(int x1, int y1, int x2, int y2,
		int r1, int r2, int m1, int m2);
		pair_t p;
		p.first_x = POS_W'(x1); p.first_y = POS_W'(y1);
		p.second_x = POS_W'(x2); p.second_y = POS_W'(y2);
		p.first_radius = RAD_W'(r1); p.second_radius = RAD_W'(r2);
		p.first_mass = MASS_W'(m1); p.second_mass = MASS_W'(m2);
		return p;
	endfunction

	function automatic void add_pending(pair_t p);
		pending_pairs.insert(pending_pairs.size(), p);
	endfunction

	function automatic pair_t random_pair();
		pair_t p;
		int kind, span, cx, cy;
		kind = $urandom_range(0, 9);
		p.first_radius = RAD_W'($urandom);
		p.second_radius = RAD_W'($urandom);
		p.first_mass = MASS_W'($urandom);
		p.second_mass = MASS_W'($urandom);
		if (kind == 0) begin
			p.first_x = POS_W'($urandom); p.first_y = POS_W'($urandom);
			p.second_x = POS_W'($urandom); p.second_y = POS_W'($urandom);
		end else begin
			// near pair: offset within the contact distance, mostly overlapping
			span = int'(p.first_radius) + int'(p.second_radius);
			if (span < 2) span = 2;
			cx = (kind == 1) ? (($urandom_range(0, 1) != 0) ? POS_MAX : POS_MIN)
				: int'($urandom_range(0, 2 * POS_MAX)) - POS_MAX;
			cy = (kind == 2) ? (($urandom_range(0, 1) != 0) ? POS_MAX : POS_MIN)
				: int'($urandom_range(0, 2 * POS_MAX)) - POS_MAX;
			p.first_x = clamp_pos(cx);
			p.first_y = clamp_pos(cy);
			p.second_x = clamp_pos(cx + int'($urandom_range(0, span)) - span / 2);
			p.second_y = clamp_pos(cy + int'($urandom_range(0, span)) - span / 2);
			if (kind == 3) p.first_mass = '0;
			if (kind == 4) p.second_mass = '0;
			if (kind == 5) begin
				p.first_mass = '0; p.second_mass = '0;
			end
			if (kind == 6) begin
				p.second_x = p.first_x; p.second_y = p.first_y;
			end
		end
		return p;
	endfunction

	initial begin
		add_pending(make_pair(0, 0, 0, 0, 0, 0, 0, 0));
		add_pending(make_pair(0, 0, 0, 0, 100, 100, 256, 256));
		add_pending(make_pair(10, 20, 10, 20, 5, 5, 0, 0));
		add_pending(make_pair(100, 0, 0, 0, 60, 40, 256, 256));
		add_pending(make_pair(99, 0, 0, 0, 60, 40, 256, 256));
		add_pending(make_pair(5, 5, 0, 0, 10, 10, 0, 0));
		add_pending(make_pair(5, 5, 0, 0, 10, 10, 0, 300));
		add_pending(make_pair(5, -5, 0, 0, 10, 10, 300, 0));
		add_pending(make_pair(POS_MAX, POS_MAX, POS_MAX - 1, POS_MAX - 1,
			65535, 65535, 65535, 65535));
		add_pending(make_pair(POS_MIN, POS_MIN, POS_MIN + 1, POS_MIN + 1,
			65535, 65535, 65535, 65535));
		add_pending(make_pair(POS_MAX, POS_MIN, POS_MIN, POS_MAX,
			65535, 65535, 65535, 65535));
		add_pending(make_pair(POS_MAX - 3, 0, POS_MAX, 0, 65535, 65535, 1, 65535));
		add_pending(make_pair(-1, -1, 0, 0, 1, 1, 1, 1));
		add_pending(make_pair(3, 0, 0, 0, 2, 2, 1, 2));
		add_pending(make_pair(0, -70000, 0, 0, 65535, 65535, 65535, 1));
		add_pending(make_pair(-131070, 0, 0, 0, 65535, 65535, 2, 2));
		for (int i = 0; i < 1950; i++) add_pending(random_pair());
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		wait (feeding_done);
		while (expected_results.size() > 0) @(posedge clk);
		repeat (PIPE_LAT + 10) @(posedge clk);
		$display("checked %0d results: %0d resolved, %0d degenerate, %0d apart",
			checked, n_resolved, n_degen, n_apart);
		if (mismatches == 0 && expected_results.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("%0d mismatches, %0d results missing", mismatches,
				expected_results.size());
			$display("Mismatches found");
		end
		$finish;
	end

	initial begin
		#10ms;
		$display("timeout");
		$display("Mismatches found");
		$finish;
	end

endmodule

[sim.f]
design/cpcr_pkg.sv
design/cpcr_isqrt.sv
design/cpcr_div.sv
design/circle_pair_collision_resolve.sv
design/cpcr_check.sv
test/circle_pair_collision_resolve_tb.sv
